// ===== sv/bsm_pkg.sv =====
// Shared types and constants for the bank switch mapper with scanline IRQ.
package bsm_pkg;

  // Default bank widths for the top-level parameters.
  localparam int unsigned PATTERN_BANK_BITS_DEF = 8;
  localparam int unsigned PROGRAM_BANK_BITS_DEF = 4;

  // Fixed field widths.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned ROM_ADDR_W = 18;
  localparam int unsigned MIRROR_W   = 2;
  localparam int unsigned PAGES_W    = 5;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned RELOAD_W   = 16;
  localparam int unsigned PAGE_W     = 4;

  typedef enum logic [OP_W-1:0] {
    OP_REG_WRITE = 2'd0,
    OP_TICK      = 2'd1,
    OP_PAT_FETCH = 2'd2,
    OP_PRG_FETCH = 2'd3
  } op_e;

  // Register block bases (address bits 15:4).
  localparam logic [11:0] BASE_COUNT_LO = 12'h600;
  localparam logic [11:0] BASE_COUNT_HI = 12'h7FF;
  localparam logic [11:0] BASE_LATCH    = 12'h800;

  // Register offsets (address bits 3:0); 0..7 select the pattern banks.
  localparam logic [3:0] REG_PAT_FIRST = 4'h0;
  localparam logic [3:0] REG_PAT_LAST  = 4'h7;
  localparam logic [3:0] REG_PRG_BANK  = 4'h8;
  localparam logic [3:0] REG_MIRROR    = 4'h9;
  localparam logic [3:0] REG_IRQ_EN    = 4'hA;
  localparam logic [3:0] REG_COUNT_LO  = 4'hB;
  localparam logic [3:0] REG_COUNT_HI  = 4'hC;

  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 17'd342;
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'd342;
  localparam logic [PAGES_W-1:0]  PAGES_RESET  = 5'd16;
  localparam logic [PAGES_W-1:0]  PAGES_MAX    = 5'd16;

endpackage

// ===== sv/bank_switch_mapper_scanline_irq.sv =====
// Bank switch cartridge mapper with a scanline interrupt counter.
//
//   Channel | Direction | Handshake              | Beat payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | sink      | in_valid_i / in_stall_o | operation, address, value
//   out     | source    | out_valid_o / out_stall_i | rom_address, rom_is_pattern, mirror, irq
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | program page count (5 bits)
//
// Every input beat produces exactly one output beat, registered in the cycle after it is
// accepted. The state update and the result are both computed combinationally from the
// beat and the mapper registers, so the block sustains one beat per clock unless stalled.
// Reset is asynchronous and active low; it returns every mapper register to its
// power-on value and empties the result register.
// A stall on the output holds the result register and stalls the input in the same
// cycle; the input is taken again as soon as the result is taken or the register empties.
module bank_switch_mapper_scanline_irq #(
  parameter int unsigned PATTERN_BANK_BITS = bsm_pkg::PATTERN_BANK_BITS_DEF,
  parameter int unsigned PROGRAM_BANK_BITS = bsm_pkg::PROGRAM_BANK_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Item input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bsm_pkg::OP_W-1:0]           in_operation_i,
  input  logic [bsm_pkg::ADDR_W-1:0]         in_address_i,
  input  logic [bsm_pkg::VALUE_W-1:0]        in_value_i,
  // Result output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bsm_pkg::ROM_ADDR_W-1:0]     out_rom_address_o,
  output logic                               out_rom_is_pattern_o,
  output logic [bsm_pkg::MIRROR_W-1:0]       out_mirroring_mode_o,
  output logic                               out_irq_line_o,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bsm_pkg::PAGES_W-1:0]        cfg_data_i
);
  import bsm_pkg::*;

  // Mapper state.
  logic [PATTERN_BANK_BITS-1:0] pat_bank_q [8];
  logic [PATTERN_BANK_BITS-1:0] pat_bank_d [8];
  logic [PROGRAM_BANK_BITS-1:0] prg_bank_q, prg_bank_d;
  logic [MIRROR_W-1:0]          mirror_q, mirror_d;
  logic                         irq_en_q, irq_en_d;
  logic [COUNT_W-1:0]           count_q, count_d;
  logic [RELOAD_W-1:0]          reload_q, reload_d;
  logic                         pending_q, pending_d;
  logic [PAGES_W-1:0]           pages_q;

  // Result register.
  logic                  out_valid_q;
  logic [ROM_ADDR_W-1:0] rom_addr_q, rom_addr_d;
  logic                  is_pat_q, is_pat_d;
  logic [MIRROR_W-1:0]   out_mirror_q;
  logic                  out_irq_q;

  logic in_accept;
  op_e  op;

  // Address decode for register writes.
  logic [11:0]        base;
  logic [3:0]         offset;
  logic               base_hit;
  logic               is_latch;
  logic [COUNT_W-1:0] count_sel;
  logic [COUNT_W-1:0] count_dec;

  // Fetch translation.
  logic [12:0]         pat_addr;
  logic [7:0]          pat_page;
  logic [PAGE_W-1:0]   last_page;
  logic [PAGE_W-1:0]   prg_page;

  // The result register frees up whenever its beat is taken, so the input is only
  // held off while a result sits stalled.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign op       = op_e'(in_operation_i);
  assign base     = in_address_i[15:4];
  assign offset   = in_address_i[3:0];
  assign is_latch = (base == BASE_LATCH);
  assign base_hit = (base == BASE_COUNT_LO) || (base == BASE_COUNT_HI) || is_latch;

  // The enable write reloads the counter only at the latch block.
  assign count_sel = is_latch ? COUNT_W'(reload_q) : count_q;
  assign count_dec = count_q - COUNT_W'(1);

  // Next mapper state for the beat being accepted.
  always_comb begin
    pat_bank_d = pat_bank_q;
    prg_bank_d = prg_bank_q;
    mirror_d   = mirror_q;
    irq_en_d   = irq_en_q;
    count_d    = count_q;
    reload_d   = reload_q;
    pending_d  = pending_q;
    case (op)
      OP_REG_WRITE: begin
        if (base_hit) begin
          case (offset) inside
            [REG_PAT_FIRST:REG_PAT_LAST]: begin
              pat_bank_d[offset[2:0]] = in_value_i[PATTERN_BANK_BITS-1:0];
            end
            REG_PRG_BANK: begin
              prg_bank_d = in_value_i[PROGRAM_BANK_BITS-1:0];
            end
            REG_MIRROR: begin
              mirror_d = in_value_i[MIRROR_W-1:0];
            end
            REG_IRQ_EN: begin
              // Enabling re-raises the request only when the counter already sits
              // at zero; any enable write first clears a pending request.
              irq_en_d  = in_value_i[0];
              count_d   = count_sel;
              pending_d = in_value_i[0] && (count_sel == '0);
            end
            REG_COUNT_LO: begin
              if (is_latch) begin
                reload_d = {reload_q[15:8], in_value_i};
              end else begin
                count_d = {1'b0, count_q[15:8], in_value_i};
              end
            end
            REG_COUNT_HI: begin
              if (is_latch) begin
                reload_d = {in_value_i, reload_q[7:0]};
              end else begin
                count_d = {1'b0, in_value_i, count_q[7:0]};
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_TICK: begin
        // Counting past zero fires the request, stops the counter and parks it at -1.
        if (irq_en_q) begin
          if (count_dec[COUNT_W-1]) begin
            pending_d = 1'b1;
            irq_en_d  = 1'b0;
            count_d   = '1;
          end else begin
            count_d = count_dec;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // The upper 16K window always maps the last page; a page count of zero acts as one
  // and anything above sixteen acts as sixteen.
  always_comb begin
    if (pages_q == '0) begin
      last_page = '0;
    end else if (pages_q > PAGES_MAX) begin
      last_page = '1;
    end else begin
      last_page = PAGE_W'(pages_q - PAGES_W'(1));
    end
  end

  assign pat_addr = in_address_i[12:0];
  assign pat_page = 8'(pat_bank_q[pat_addr[12:10]]);
  assign prg_page = in_address_i[14] ? last_page : PAGE_W'(prg_bank_q);

  // Result fields; writes and ticks report a zero address.
  always_comb begin
    rom_addr_d = '0;
    is_pat_d   = 1'b0;
    case (op)
      OP_PAT_FETCH: begin
        rom_addr_d = {pat_page, pat_addr[9:0]};
        is_pat_d   = 1'b1;
      end
      OP_PRG_FETCH: begin
        if (in_address_i[15]) begin
          rom_addr_d = {prg_page, in_address_i[13:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        pat_bank_q[i] <= '0;
      end
      prg_bank_q <= '0;
      mirror_q   <= '0;
      irq_en_q   <= 1'b0;
      count_q    <= COUNT_RESET;
      reload_q   <= RELOAD_RESET;
      pending_q  <= 1'b0;
    end else if (in_accept) begin
      pat_bank_q <= pat_bank_d;
      prg_bank_q <= prg_bank_d;
      mirror_q   <= mirror_d;
      irq_en_q   <= irq_en_d;
      count_q    <= count_d;
      reload_q   <= reload_d;
      pending_q  <= pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q <= PAGES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pages_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Mirroring and IRQ are reported as they stand after the beat.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rom_addr_q   <= rom_addr_d;
      is_pat_q     <= is_pat_d;
      out_mirror_q <= mirror_d;
      out_irq_q    <= pending_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_rom_address_o    = rom_addr_q;
  assign out_rom_is_pattern_o = is_pat_q;
  assign out_mirroring_mode_o = out_mirror_q;
  assign out_irq_line_o       = out_irq_q;

endmodule

// ===== tb/tb_bank_switch_mapper_scanline_irq.sv =====
// Self-checking testbench for the bank switch mapper with scanline IRQ.
`timescale 1ns / 100ps

module tb_bank_switch_mapper_scanline_irq;
  import bsm_pkg::*;

  // A phase ends only when the pipe is empty, so a cycle count with nothing
  // accepted on any channel is a hang. The longest legal quiet stretch is the
  // forced receiver hold-off of HOLD_CYCLES, so the limit leaves wide margin.
  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT_COUNT = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_BEATS   = 285;

  // Register offset outside the decoded map; writes there must be dropped.
  localparam logic [3:0] OFF_UNUSED = 4'hD;

  typedef struct packed {
    op_e                 op;
    logic [ADDR_W-1:0]   address;
    logic [VALUE_W-1:0]  value;
  } mapper_beat_t;

  typedef struct packed {
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  rom_is_pattern;
    logic [MIRROR_W-1:0]   mirroring_mode;
    logic                  irq_line;
  } mapper_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // Clock, reset and all block inputs start at known values.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       in_operation_i = '0;
  logic [ADDR_W-1:0]     in_address_i = '0;
  logic [VALUE_W-1:0]    in_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [ROM_ADDR_W-1:0] out_rom_address_o;
  logic                  out_rom_is_pattern_o;
  logic [MIRROR_W-1:0]   out_mirroring_mode_o;
  logic                  out_irq_line_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [PAGES_W-1:0]    cfg_data_i = '0;

  // Mapper state as the testbench predicts it.
  logic [7:0]            pat_bank [8];
  logic [PAGE_W-1:0]     prg_bank;
  logic [MIRROR_W-1:0]   mirror_sel;
  logic                  irq_en;
  logic [COUNT_W-1:0]    scan_count;
  logic [RELOAD_W-1:0]   scan_reload;
  logic                  irq_pend;
  logic [PAGES_W-1:0]    page_count;

  // Beats waiting to be sent, and results the block still owes us.
  mapper_beat_t          pending_beats [$];
  mapper_result_t        expected_results [$];
  mapper_beat_t          cur_beat;

  int beats_queued;
  int directed_count;
  int beats_sent;
  int results_seen;
  int irq_results;
  int page_writes;
  int fail_count;

  // Sender burst shaping, owned by the driver.
  int burst_left;
  int gap_left;

  // Receiver stall pattern and the one long hold-off, owned by the receiver.
  stall_mode_e stall_mode;
  int          mode_left;
  int          periodic_cnt;
  int          hold_left;
  bit          hold_done;

  int quiet_cycles;

  bank_switch_mapper_scanline_irq u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_operation_i       (in_operation_i),
    .in_address_i         (in_address_i),
    .in_value_i           (in_value_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_rom_address_o    (out_rom_address_o),
    .out_rom_is_pattern_o (out_rom_is_pattern_o),
    .out_mirroring_mode_o (out_mirroring_mode_o),
    .out_irq_line_o       (out_irq_line_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicts the result of one beat and advances the mapper state with it.
  // The result always shows mirroring and IRQ as they stand after the beat.
  function automatic mapper_result_t map_access(mapper_beat_t b);
    mapper_result_t      res;
    logic [11:0]         base;
    logic [3:0]          off;
    logic                latch;
    logic [PAGES_W-1:0]  pages;
    logic [12:0]         pat_addr;
    logic [PAGE_W-1:0]   page;
    res   = '0;
    base  = b.address[15:4];
    off   = b.address[3:0];
    latch = (base == BASE_LATCH);
    case (b.op)
      OP_REG_WRITE: begin
        // The same register file shows up in three address blocks; the
        // latch block differs only for the counter bytes and the enable.
        if (base == BASE_COUNT_LO || base == BASE_COUNT_HI || latch) begin
          if (off <= REG_PAT_LAST) begin
            pat_bank[off[2:0]] = 8'(b.value & ((1 << PATTERN_BANK_BITS_DEF) - 1));
          end else begin
            case (off)
              REG_PRG_BANK: prg_bank = b.value[PAGE_W-1:0];
              REG_MIRROR:   mirror_sel = b.value[MIRROR_W-1:0];
              REG_IRQ_EN: begin
                // Any enable write drops a pending IRQ; it comes straight
                // back only when the counter already sits at zero.
                irq_en   = b.value[0];
                irq_pend = 1'b0;
                if (latch) scan_count = {1'b0, scan_reload};
                if (irq_en && scan_count == '0) irq_pend = 1'b1;
              end
              REG_COUNT_LO: begin
                if (latch) scan_reload[7:0] = b.value;
                else scan_count = {1'b0, scan_count[15:8], b.value};
              end
              REG_COUNT_HI: begin
                if (latch) scan_reload[15:8] = b.value;
                else scan_count = {1'b0, b.value, scan_count[7:0]};
              end
              default: ;
            endcase
          end
        end
      end
      OP_TICK: begin
        // Going below zero fires the IRQ, disables the counter and parks it
        // at all ones until it is written again.
        if (irq_en) begin
          scan_count = scan_count - 1'b1;
          if (scan_count[COUNT_W-1]) begin
            irq_pend   = 1'b1;
            irq_en     = 1'b0;
            scan_count = '1;
          end
        end
      end
      OP_PAT_FETCH: begin
        pat_addr = b.address[12:0];
        res.rom_address    = {pat_bank[pat_addr[12:10]], pat_addr[9:0]};
        res.rom_is_pattern = 1'b1;
      end
      default: begin
        // Program fetches below 0x8000 map nowhere and return zero.
        if (b.address[15]) begin
          if (b.address[14]) begin
            pages = page_count;
            if (pages == '0) pages = PAGES_W'(1);
            if (pages > PAGES_MAX) pages = PAGES_MAX;
            page = PAGE_W'(pages - 1'b1);
          end else begin
            page = prg_bank;
          end
          res.rom_address = {page, b.address[13:0]};
        end
      end
    endcase
    res.mirroring_mode = mirror_sel;
    res.irq_line       = irq_pend;
    return res;
  endfunction

  task automatic flag(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic queue_beat(op_e op, logic [ADDR_W-1:0] addr, logic [VALUE_W-1:0] data);
    mapper_beat_t b;
    b.op      = op;
    b.address = addr;
    b.value   = data;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  function automatic logic [11:0] pick_base();
    case ($urandom_range(0, 2))
      0:       return BASE_COUNT_LO;
      1:       return BASE_COUNT_HI;
      default: return BASE_LATCH;
    endcase
  endfunction

  // One independent beat. Most writes land in the decoded map; the rest go to
  // fully random addresses, which are nearly always ignored.
  task automatic queue_random_beat();
    int               pick;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    addr = ADDR_W'($urandom);
    if (pick < 30) begin
      if ($urandom_range(0, 4) != 0) addr = {pick_base(), 4'($urandom_range(0, 15))};
      queue_beat(OP_REG_WRITE, addr, VALUE_W'($urandom));
    end else if (pick < 48) begin
      queue_beat(OP_TICK, addr, VALUE_W'($urandom));
    end else if (pick < 72) begin
      if ($urandom_range(0, 3) != 0) addr = {3'b000, addr[12:0]};
      queue_beat(OP_PAT_FETCH, addr, VALUE_W'($urandom));
    end else begin
      queue_beat(OP_PRG_FETCH, addr, VALUE_W'($urandom));
    end
  endtask

  // A scanline IRQ setup: load a small count through either the counter or
  // the latch, enable, tick it down, often past zero, and sometimes acknowledge.
  task automatic queue_irq_sequence();
    logic [11:0] base;
    int          steps;
    base  = pick_base();
    steps = $urandom_range(0, 9);
    queue_beat(OP_REG_WRITE, {base, REG_COUNT_LO}, VALUE_W'($urandom_range(0, 6)));
    queue_beat(OP_REG_WRITE, {(base == BASE_LATCH) ? BASE_LATCH : pick_base(), REG_COUNT_HI},
               ($urandom_range(0, 9) == 0) ? VALUE_W'($urandom) : '0);
    queue_beat(OP_REG_WRITE, {base, REG_IRQ_EN},
               ($urandom_range(0, 9) == 0) ? VALUE_W'($urandom) : (VALUE_W'($urandom) | 8'h01));
    repeat (steps) begin
      if ($urandom_range(0, 3) != 0) queue_beat(OP_TICK, ADDR_W'($urandom), VALUE_W'($urandom));
      else queue_random_beat();
    end
    if ($urandom_range(0, 1) != 0)
      queue_beat(OP_REG_WRITE, {pick_base(), REG_IRQ_EN}, VALUE_W'($urandom));
  endtask

  task automatic queue_random_phase(int count);
    int target;
    target = beats_queued + count;
    while (beats_queued < target) begin
      if ($urandom_range(0, 9) < 3) queue_irq_sequence();
      else queue_random_beat();
    end
  endtask

  // Waits until every queued beat has gone in and every result has come out,
  // then lets the pipe settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Page count writes happen only with the mapper drained.
  task automatic write_page_count(logic [PAGES_W-1:0] pages);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pages;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    page_count = pages;
    page_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: presents one beat at a time from the pending queue. A beat stays
  // on the bus unchanged until it is taken; gaps only open between beats.
  always @(posedge clk_i) begin
    bit taken;
    if (rst_ni) begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        expected_results.push_back(map_access(cur_beat));
        beats_sent++;
      end
      if (!in_valid_i || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          cur_beat = pending_beats.pop_front();
          in_operation_i <= cur_beat.op;
          in_address_i   <= cur_beat.address;
          in_value_i     <= cur_beat.value;
          in_valid_i     <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 9) == 0) begin
            // An occasional long run with no idle cycles at all.
            burst_left = $urandom_range(150, 300);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = $urandom_range(0, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: changes its stall pattern every so often, and once, after a few
  // hundred results, holds off long enough that the block backs up and
  // stalls its input while the driver keeps offering beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT_COUNT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(32, 200);
        end else begin
          mode_left--;
        end
        periodic_cnt++;
        case (stall_mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
          default:     out_stall_i <= (periodic_cnt % 4 != 0);
        endcase
      end
    end
  end

  // Monitor: each result beat taken is checked against the oldest prediction.
  always @(posedge clk_i) begin
    mapper_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_irq_line_o) irq_results++;
      if (expected_results.size() == 0) begin
        flag($sformatf("result beat %0d arrived with no beat outstanding", results_seen));
      end else begin
        want = expected_results.pop_front();
        if (out_rom_address_o !== want.rom_address)
          flag($sformatf("result %0d rom_address: expected %h, got %h",
                         results_seen, want.rom_address, out_rom_address_o));
        if (out_rom_is_pattern_o !== want.rom_is_pattern)
          flag($sformatf("result %0d rom_is_pattern: expected %b, got %b",
                         results_seen, want.rom_is_pattern, out_rom_is_pattern_o));
        if (out_mirroring_mode_o !== want.mirroring_mode)
          flag($sformatf("result %0d mirroring_mode: expected %0d, got %0d",
                         results_seen, want.mirroring_mode, out_mirroring_mode_o));
        if (out_irq_line_o !== want.irq_line)
          flag($sformatf("result %0d irq_line: expected %b, got %b",
                         results_seen, want.irq_line, out_irq_line_o));
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat on any channel for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [PAGES_W-1:0] settings [6];
    for (int i = 0; i < 8; i++) pat_bank[i] = '0;
    prg_bank    = '0;
    mirror_sel  = '0;
    irq_en      = 1'b0;
    scan_count  = COUNT_RESET;
    scan_reload = RELOAD_RESET;
    irq_pend    = 1'b0;
    page_count  = PAGES_RESET;
    stall_mode  = STALL_NONE;

    // One page, zero and a value past the top (both clamp), just above the
    // largest legal count, the full 16, then a random legal count.
    settings = '{5'd1, 5'd0, 5'd31, 5'd17, PAGES_MAX, 5'($urandom_range(1, 16))};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: reset banks, the fixed last window, a program fetch
    // below the switchable window, the extremes of bank and data values,
    // pattern addresses past 0x1FFF, ignored writes, a tick on a disabled
    // counter, an enable that fires at once from a zero latch, and a count
    // written directly and ticked through zero.
    queue_beat(OP_PAT_FETCH, 16'h0000, 8'h00);
    queue_beat(OP_PRG_FETCH, 16'hC000, 8'hFF);
    queue_beat(OP_PRG_FETCH, 16'h7FFF, 8'h00);
    queue_beat(OP_REG_WRITE, {BASE_COUNT_LO, REG_PAT_FIRST}, 8'hFF);
    queue_beat(OP_REG_WRITE, {BASE_COUNT_HI, REG_PAT_LAST}, 8'hA5);
    queue_beat(OP_REG_WRITE, {BASE_LATCH, 4'(REG_PAT_FIRST + 3)}, 8'h5A);
    queue_beat(OP_PAT_FETCH, 16'h1FFF, 8'h00);
    queue_beat(OP_PAT_FETCH, 16'hFC00, 8'h00);
    queue_beat(OP_PAT_FETCH, 16'h0C00, 8'h00);
    queue_beat(OP_REG_WRITE, {BASE_LATCH, REG_PRG_BANK}, 8'hFF);
    queue_beat(OP_PRG_FETCH, 16'h8000, 8'h00);
    queue_beat(OP_PRG_FETCH, 16'hFFFF, 8'h00);
    queue_beat(OP_REG_WRITE, {BASE_COUNT_LO, REG_MIRROR}, 8'hFF);
    queue_beat(OP_REG_WRITE, {BASE_COUNT_LO, OFF_UNUSED}, 8'hFF);
    queue_beat(OP_REG_WRITE, 16'h1234, 8'h00);
    queue_beat(OP_TICK, 16'hFFFF, 8'hFF);
    queue_beat(OP_REG_WRITE, {BASE_LATCH, REG_COUNT_LO}, 8'h00);
    queue_beat(OP_REG_WRITE, {BASE_LATCH, REG_COUNT_HI}, 8'h00);
    queue_beat(OP_REG_WRITE, {BASE_LATCH, REG_IRQ_EN}, 8'h01);
    queue_beat(OP_TICK, 16'h0000, 8'h00);
    queue_beat(OP_REG_WRITE, {BASE_COUNT_LO, REG_COUNT_LO}, 8'h02);
    queue_beat(OP_REG_WRITE, {BASE_COUNT_HI, REG_COUNT_HI}, 8'h00);
    queue_beat(OP_REG_WRITE, {BASE_COUNT_LO, REG_IRQ_EN}, 8'h01);
    repeat (3) queue_beat(OP_TICK, 16'h0000, 8'h00);
    queue_beat(OP_REG_WRITE, {BASE_COUNT_HI, REG_IRQ_EN}, 8'h00);
    directed_count = beats_queued;

    queue_random_phase(PHASE_BEATS);
    wait_drained();
    foreach (settings[i]) begin
      write_page_count(settings[i]);
      queue_random_phase(PHASE_BEATS);
      wait_drained();
    end

    $display("Run covered %0d beats (%0d directed) across %0d page count settings,",
             beats_sent, directed_count, page_writes + 1);
    $display("with %0d results checked, %0d of them with the IRQ line high.",
             results_seen, irq_results);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
